// ===== design/fifo_with_positional_remove_search_assert.svh =====
// Assertion macros for the positional-remove FIFO checker.
// Expects clk and rst_n in the scope of use; depends on nothing else.
`ifndef FIFO_WITH_POSITIONAL_REMOVE_SEARCH_ASSERT_SVH
`define FIFO_WITH_POSITIONAL_REMOVE_SEARCH_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define FPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fpr_pkg.sv =====
// Shared constants, codes and controller/datapath types for the
// positional-remove FIFO. No dependencies.
package fpr_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OP_W    = 2;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_REM  = 2'd2;
  localparam logic [OP_W-1:0] OP_SRCH = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic            latch;      // capture input word, clear result
    logic            wr_tail;    // append value, bump count
    logic            st_en;      // set result status
    logic [ST_W-1:0] st_code;
    logic            rd_head;    // read entry 0
    logic            cap_head;   // keep read data as dequeued value
    logic            idx_pos;    // index <= position - 1
    logic            idx_zero;   // index <= 0
    logic            shift_rd;   // read entry index + 1
    logic            shift_wr;   // write read data to index, advance
    logic            cnt_dec;    // drop one entry from count
    logic            srch_rd;    // read entry index
    logic            idx_inc;    // advance index
    logic            set_found;  // flag search hit
    logic            out_load;   // move result into output register
  } fpr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            pos_bad;
    logic            at_last;    // index names the last stored entry
    logic            srch_hit;
    logic            out_free;
  } fpr_stat_t;

endpackage

// ===== design/fpr_if.sv =====
// Valid/ready channel interfaces for the positional-remove FIFO.
// Depends on fpr_pkg for field widths.
interface fpr_in_if;
  logic                                valid;
  logic                                ready;
  logic [fpr_pkg::OP_W-1:0]            opcode;
  logic signed [fpr_pkg::VAL_W-1:0]    item_value;
  logic [fpr_pkg::POS_W-1:0]           position;

  modport source (output valid, opcode, item_value, position, input ready);
  modport sink   (input valid, opcode, item_value, position, output ready);
endinterface

interface fpr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpr_pkg::VAL_W-1:0]    head_value;
  logic [fpr_pkg::ST_W-1:0]            status;
  logic                                found;
  logic [fpr_pkg::COUNT_W-1:0]         count;

  modport source (output valid, head_value, status, found, count, input ready);
  modport sink   (input valid, head_value, status, found, count, output ready);
endinterface

// ===== design/fifo_with_positional_remove_search.sv =====
// Bounded FIFO of 32-bit IDs with enqueue, dequeue, remove at a 1-based
// position and search, one result word per input word. Entries live in a
// single-port-read memory with the head at entry 0, so every access walks it
// one entry at a time. Enqueue and every error go straight to the result;
// dequeue reads the head and remove starts at the position, then both close
// the gap by moving each later entry one place toward the head, one entry
// per read/write step pair; search reads and compares entries from the head,
// stopping at the first match. The block takes one word at a time; the input
// is ready again once the result is loaded into the output register,
// which holds it until taken. No clearing pass is needed after reset.
// Depends on fpr_pkg, fpr_if, fpr_ctrl and fpr_dpath.
module fifo_with_positional_remove_search #(
  parameter int DEPTH = fpr_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fpr_in_if.sink           in_ch,
  fpr_out_if.source        out_ch
);

  fpr_pkg::fpr_cmd_t  cmd;
  fpr_pkg::fpr_stat_t stat;

  // Sequencer
  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result path
  fpr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_ch.opcode),
    .in_item_value  (in_ch.item_value),
    .in_position    (in_ch.position),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_head_value (out_ch.head_value),
    .out_status     (out_ch.status),
    .out_found      (out_ch.found),
    .out_count      (out_ch.count)
  );

endmodule

// ===== design/fpr_ctrl.sv =====
// Sequencer for the positional-remove FIFO: decodes each word and steps
// the datapath through append, shift and search. Depends on fpr_pkg.
module fpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpr_pkg::fpr_stat_t stat,
  output fpr_pkg::fpr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_SRRD  = 3'd5;
  localparam logic [2:0] S_SRCMP = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          fpr_pkg::OP_ENQ: begin
            if (stat.full) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = fpr_pkg::ST_FULL;
            end else begin
              cmd.wr_tail = 1'b1;
            end
            state_nxt = S_FIN;
          end
          fpr_pkg::OP_DEQ: begin
            if (stat.empty) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = fpr_pkg::ST_EMPTY;
              state_nxt   = S_FIN;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_HEAD;
            end
          end
          fpr_pkg::OP_REM: begin
            if (stat.empty) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = fpr_pkg::ST_EMPTY;
              state_nxt   = S_FIN;
            end else if (stat.pos_bad) begin
              cmd.st_en   = 1'b1;
              cmd.st_code = fpr_pkg::ST_BADPOS;
              state_nxt   = S_FIN;
            end else begin
              cmd.idx_pos = 1'b1;
              state_nxt   = S_SHRD;
            end
          end
          default: begin
            // search; an empty queue finds nothing
            if (stat.empty) begin
              state_nxt = S_FIN;
            end else begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_SRRD;
            end
          end
        endcase
      end
      S_HEAD: begin
        cmd.cap_head = 1'b1;
        cmd.idx_zero = 1'b1;
        state_nxt    = S_SHRD;
      end
      S_SHRD: begin
        if (stat.at_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHRD;
      end
      S_SRRD: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = S_SRCMP;
      end
      S_SRCMP: begin
        if (stat.srch_hit) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_FIN;
        end else if (stat.at_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRRD;
        end
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/fpr_dpath.sv =====
// Datapath for the positional-remove FIFO: entry memory, count, walk index,
// result and output registers. Depends on fpr_pkg.
module fpr_dpath #(
  parameter int DEPTH = fpr_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpr_pkg::fpr_cmd_t                   cmd,
  output fpr_pkg::fpr_stat_t                  stat,
  input  logic [fpr_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [fpr_pkg::VAL_W-1:0]    in_item_value,
  input  logic [fpr_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fpr_pkg::VAL_W-1:0]    out_head_value,
  output logic [fpr_pkg::ST_W-1:0]            out_status,
  output logic                                out_found,
  output logic [fpr_pkg::COUNT_W-1:0]         out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > fpr_pkg::POS_W) ? CW : fpr_pkg::POS_W;
  localparam int VW = fpr_pkg::VAL_W;

  logic [VW-1:0]               ram [DEPTH];
  logic [VW-1:0]               rd_data_r;

  logic [fpr_pkg::OP_W-1:0]    op_r;
  logic [VW-1:0]               val_r;
  logic [fpr_pkg::POS_W-1:0]   pos_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               cnt_nxt;
  logic [AW-1:0]               idx_r;

  logic [VW-1:0]               head_r;
  logic [fpr_pkg::ST_W-1:0]    status_r;
  logic                        found_r;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [VW-1:0]               out_head_r;
  logic [fpr_pkg::ST_W-1:0]    out_status_r;
  logic                        out_found_r;
  logic [fpr_pkg::COUNT_W-1:0] out_count_r;

  logic [CW-1:0]               idx_p1;
  logic [MW-1:0]               pos_ext;
  logic [MW-1:0]               cnt_ext;
  logic [MW-1:0]               pos_m1;
  logic [CW+fpr_pkg::COUNT_W-1:0] cnt_wide;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [VW-1:0]               wr_data;

  // Index and position arithmetic
  assign idx_p1   = CW'(idx_r) + CW'(1);
  assign pos_ext  = MW'(pos_r);
  assign cnt_ext  = MW'(cnt_r);
  assign pos_m1   = pos_ext - MW'(1);
  assign cnt_wide = {{fpr_pkg::COUNT_W{1'b0}}, cnt_r};

  // Status toward the controller
  assign stat.op       = op_r;
  assign stat.empty    = (cnt_r == '0);
  assign stat.full     = (cnt_r == CW'(DEPTH));
  assign stat.pos_bad  = (pos_r == '0) || (pos_ext > cnt_ext);
  assign stat.at_last  = (idx_p1 == cnt_r);
  assign stat.srch_hit = (rd_data_r == val_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // Select the memory read and write ports
  assign rd_en   = cmd.rd_head | cmd.shift_rd | cmd.srch_rd;
  assign wr_en   = cmd.wr_tail | cmd.shift_wr;
  assign wr_addr = cmd.wr_tail ? cnt_r[AW-1:0] : idx_r;
  assign wr_data = cmd.wr_tail ? val_r : rd_data_r;

  always_comb begin
    rd_addr = idx_r;
    if (cmd.rd_head) begin
      rd_addr = '0;
    end else if (cmd.shift_rd) begin
      rd_addr = idx_p1[AW-1:0];
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ram[rd_addr];
    end
  end

  // Occupancy count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.wr_tail) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Capture the input word and track the walk index
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      val_r <= in_item_value;
      pos_r <= in_position;
    end
    if (cmd.idx_pos) begin
      idx_r <= pos_m1[AW-1:0];
    end else if (cmd.idx_zero) begin
      idx_r <= '0;
    end else if (cmd.idx_inc || cmd.shift_wr) begin
      idx_r <= idx_p1[AW-1:0];
    end
  end

  // Build the result of the current word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      head_r   <= '0;
      status_r <= fpr_pkg::ST_OK;
      found_r  <= 1'b0;
    end else begin
      if (cmd.st_en) begin
        status_r <= cmd.st_code;
      end
      if (cmd.cap_head) begin
        head_r <= rd_data_r;
      end
      if (cmd.set_found) begin
        found_r <= 1'b1;
      end
    end
  end

  // Output register: load a finished result, drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_head_r   <= head_r;
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= cnt_wide[fpr_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_head_value = out_head_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_count      = out_count_r;

endmodule

// ===== design/fpr_check.sv =====
// Port-level checks for the positional-remove FIFO, bound to the top level.
// Depends on fpr_pkg and the assertion macro header.
`include "fifo_with_positional_remove_search_assert.svh"

module fpr_check #(
  parameter int DEPTH = fpr_pkg::DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [fpr_pkg::VAL_W-1:0]   out_head_value,
  input logic [fpr_pkg::ST_W-1:0]           out_status,
  input logic                               out_found,
  input logic [fpr_pkg::COUNT_W-1:0]        out_count
);

  // One word in flight: ready drops right after an accept
  `FPR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted while busy")

  // Errors never carry a dequeued value
  `FPR_ASSERT_NOW(a_err_zero_head, out_valid && (out_status != fpr_pkg::ST_OK), out_head_value == '0, "error word carries data")

  // A search hit is always a good status
  `FPR_ASSERT_NOW(a_found_ok, out_valid && out_found, out_status == fpr_pkg::ST_OK, "found with error status")

  // Count stays within capacity
  `FPR_ASSERT_NOW(a_count_cap, out_valid, (DEPTH > 31) || (out_count <= 5'(DEPTH)), "count beyond capacity")

  // Stalled result holds
  `FPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_head_value) && $stable(out_status) && $stable(out_found) && $stable(out_count), "stalled result changed")

endmodule

bind fifo_with_positional_remove_search fpr_check #(
  .DEPTH (DEPTH)
) u_fpr_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_head_value (out_ch.head_value),
  .out_status     (out_ch.status),
  .out_found      (out_ch.found),
  .out_count      (out_ch.count)
);

// ===== sim/fifo_with_positional_remove_search_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the positional-remove FIFO: watches both channels, keeps
// its own copy of the queue and compares every result word field by field.
// Depends on fpr_pkg and the channel interfaces in fpr_if.
module fifo_with_positional_remove_search_checker #(
  parameter int DEPTH = fpr_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fpr_in_if    in_mon,
  fpr_out_if   out_mon,
  output int   mismatches,
  output int   waiting
);

  typedef struct packed {
    logic signed [fpr_pkg::VAL_W-1:0] head_value;
    logic [fpr_pkg::ST_W-1:0]         status;
    logic                             found;
    logic [fpr_pkg::COUNT_W-1:0]      count;
  } result_word_t;

  // Shadow copy of the stored IDs, head at index 0
  logic [fpr_pkg::VAL_W-1:0] shadow_ids [DEPTH];
  int unsigned               shadow_fill;
  result_word_t              results_due [$];
  int                        fail_tally;

  // Delete the entry at idx and pull the rest toward the head
  task automatic close_gap(input int unsigned idx);
    int unsigned k;
    for (k = idx; k + 1 < shadow_fill; k++)
      shadow_ids[k] = shadow_ids[k + 1];
    shadow_fill--;
  endtask

  // Apply one operation to the shadow queue and work out its result word
  task automatic apply_queue_op(input logic [fpr_pkg::OP_W-1:0] op,
                                input logic [fpr_pkg::VAL_W-1:0] value,
                                input logic [fpr_pkg::POS_W-1:0] pos,
                                output result_word_t res);
    int unsigned k;
    res = '0;
    case (op)
      fpr_pkg::OP_ENQ: begin
        if (shadow_fill >= DEPTH) begin
          res.status = fpr_pkg::ST_FULL;
        end else begin
          shadow_ids[shadow_fill] = value;
          shadow_fill++;
        end
      end
      fpr_pkg::OP_DEQ: begin
        if (shadow_fill == 0) begin
          res.status = fpr_pkg::ST_EMPTY;
        end else begin
          res.head_value = shadow_ids[0];
          close_gap(0);
        end
      end
      fpr_pkg::OP_REM: begin
        if (shadow_fill == 0) begin
          res.status = fpr_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > shadow_fill) begin
          res.status = fpr_pkg::ST_BADPOS;
        end else begin
          close_gap(pos - 1);
        end
      end
      default: begin
        for (k = 0; k < shadow_fill; k++)
          if (shadow_ids[k] == value) res.found = 1'b1;
      end
    endcase
    res.count = shadow_fill[fpr_pkg::COUNT_W-1:0];
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_tally++;
    end
  endtask

  // Compare taken result words first, then log the newly accepted word
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      results_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.head_value = out_mon.head_value;
        got.status     = out_mon.status;
        got.found      = out_mon.found;
        got.count      = out_mon.count;
        if (results_due.size() == 0) begin
          $error("result word with no operation pending: status %0d count %0d",
                 got.status, got.count);
          fail_tally++;
        end else begin
          want = results_due.pop_front();
          check_field("head_value", int'(want.head_value), int'(got.head_value));
          check_field("status", int'(want.status), int'(got.status));
          check_field("found", int'(want.found), int'(got.found));
          check_field("count", int'(want.count), int'(got.count));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_queue_op(in_mon.opcode, in_mon.item_value, in_mon.position, want);
        results_due.push_back(want);
      end
    end
    mismatches <= fail_tally;
    waiting    <= results_due.size();
  end

endmodule

// ===== sim/fifo_with_positional_remove_search_test.sv =====
`timescale 1ns / 1ps
// Top of the positional-remove FIFO test: clock, reset, directed and random
// operation words, random output stalls and the verdict. Depends on fpr_pkg,
// fpr_if, the block and fifo_with_positional_remove_search_checker.
module fifo_with_positional_remove_search_test;

  localparam int DEPTH        = fpr_pkg::DEPTH_DEF;
  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   cycle;
  int   mismatches;
  int   waiting;

  // Recently enqueued IDs, so searches can hit live entries
  logic [fpr_pkg::VAL_W-1:0] recent_ids [16];
  int                        recent_ptr;

  fpr_in_if  in_ch ();
  fpr_out_if out_ch ();

  fifo_with_positional_remove_search #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fifo_with_positional_remove_search_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stall the result side now and then, never while calm
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Offer one word, with an occasional gap before it, and hold it until taken
  task automatic send_word(input logic [fpr_pkg::OP_W-1:0] op,
                           input logic [fpr_pkg::VAL_W-1:0] value,
                           input logic [fpr_pkg::POS_W-1:0] pos);
    while (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= value;
    in_ch.position   <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic [fpr_pkg::OP_W-1:0]  op;
    logic [fpr_pkg::VAL_W-1:0] value;
    logic [fpr_pkg::POS_W-1:0] pos;
    int                        n;
    int                        roll;
    int                        enq_bias;

    rst_n            <= 1'b0;
    calm             <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= fpr_pkg::OP_ENQ;
    in_ch.item_value <= '0;
    in_ch.position   <= '0;
    recent_ptr = 0;
    enq_bias   = 50;
    foreach (recent_ids[i]) recent_ids[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue: dequeue, remove and search all see nothing
    send_word(fpr_pkg::OP_DEQ, 32'h0, 5'd0);
    send_word(fpr_pkg::OP_REM, 32'h0, 5'd3);
    send_word(fpr_pkg::OP_SRCH, 32'h0, 5'd0);
    // Fill to capacity, extremes first
    for (n = 0; n < DEPTH; n++) begin
      value = (n == 0) ? 32'h7FFF_FFFF : (n == 1) ? 32'h8000_0000 :
              (n == 2) ? 32'hFFFF_FFFF : n[fpr_pkg::VAL_W-1:0];
      send_word(fpr_pkg::OP_ENQ, value, 5'd0);
    end
    send_word(fpr_pkg::OP_ENQ, 32'h5A5A_5A5A, 5'd0);   // full
    send_word(fpr_pkg::OP_SRCH, 32'h8000_0000, 5'd0);  // hit
    send_word(fpr_pkg::OP_SRCH, 32'h5A5A_5A5A, 5'd0);  // miss on a full queue
    send_word(fpr_pkg::OP_REM, 32'h0, 5'd0);           // position zero
    send_word(fpr_pkg::OP_REM, 32'h0, 5'd16);          // last entry, tail moves back
    send_word(fpr_pkg::OP_ENQ, 32'h0000_0042, 5'd0);   // lands at the repaired tail
    send_word(fpr_pkg::OP_REM, 32'h0, 5'd1);           // head
    send_word(fpr_pkg::OP_REM, 32'h0, 5'd16);          // beyond count
    send_word(fpr_pkg::OP_DEQ, 32'hFFFF_FFFF, 5'd31);

    // Random words; the enqueue share drifts so the fill level sweeps
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(3))
          0: enq_bias = 20;
          1: enq_bias = 45;
          2: enq_bias = 65;
          default: enq_bias = 90;
        endcase
      end
      calm <= (n >= 700 && n < 1000);

      roll = $urandom_range(99);
      if (roll < enq_bias) begin
        op = fpr_pkg::OP_ENQ;
      end else begin
        case ($urandom_range(2))
          0: op = fpr_pkg::OP_DEQ;
          1: op = fpr_pkg::OP_REM;
          default: op = fpr_pkg::OP_SRCH;
        endcase
      end

      roll = $urandom_range(9);
      if (roll < 4) begin
        value = recent_ids[$urandom_range(15)];
      end else if (roll == 4) begin
        case ($urandom_range(3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'h0;
          default: value = 32'hFFFF_FFFF;
        endcase
      end else begin
        value = $urandom;
      end

      roll = $urandom_range(9);
      if (roll == 0) pos = 5'd0;
      else if (roll == 1) pos = 5'd16;
      else if (roll < 6) pos = 5'($urandom_range(1, 4));
      else pos = 5'($urandom_range(1, 15));

      if (op == fpr_pkg::OP_ENQ) begin
        recent_ids[recent_ptr] = value;
        recent_ptr = (recent_ptr + 1) % 16;
      end
      send_word(op, value, pos);
    end
    in_ch.valid <= 1'b0;
    calm        <= 1'b0;

    // Drain the outstanding result, then allow for the walk latency
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/fpr_pkg.sv
design/fpr_if.sv
design/fpr_ctrl.sv
design/fpr_dpath.sv
design/fifo_with_positional_remove_search.sv
design/fpr_check.sv
sim/fifo_with_positional_remove_search_checker.sv
sim/fifo_with_positional_remove_search_test.sv
